@@ design/sdlrs_pkg.sv @@
// shared types and constants for the sequence dedup, loss and rssi statistics block
// no dependencies
package sdlrs_pkg;

	localparam int SEQ_W      = 12;
	localparam int BYTES_W    = 12;
	localparam int CHAIN_W    = 3;
	localparam int RSSI_W     = 8;
	localparam int CNT_W      = 32;
	localparam int SUM_W      = 40;
	localparam int NUM_CHAINS = 4;
	localparam int MAX_CHAINS = 4;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [CHAIN_W-1:0] CHAIN_LIMIT =
		CHAIN_W'((NUM_CHAINS < MAX_CHAINS) ? NUM_CHAINS : MAX_CHAINS);

	localparam logic signed [RSSI_W-1:0] RSSI_ABSENT = 8'sh80;
	localparam logic signed [RSSI_W-1:0] RSSI_MIN_RST = 8'sh7f;
	localparam logic signed [RSSI_W-1:0] RSSI_MAX_RST = 8'sh81;
	localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = 8'sh81;

	localparam logic CMD_FRAME  = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	typedef logic signed [RSSI_W-1:0] rssi_t;

	typedef struct packed {
		logic               is_report;
		logic               is_dup;
		logic [SEQ_W-1:0]   gap;
		logic [BYTES_W-1:0] bytes;
		logic               rssi_ok;
		rssi_t              rssi_best;
	} entry_t;

endpackage

@@ design/seq_dedup_loss_rssi_stats_top.sv @@
// top level of the duplicate filter and link statistics block
// depends on sdlrs_pkg, sdlrs_front, sdlrs_queue, sdlrs_back
//
// input channel: in_valid / in_stall, one word per frame (cmd 0) or report request (cmd 1)
// output channel: out_valid / out_stall, exactly one result word per input word, in order
// a frame is classified in the cycle it is accepted: the 128-bit seen window slides,
// the frame is checked and marked, the sequence gap and best chain rssi are formed
// the classified word waits in a four-entry queue for the counter stage
// the counter stage updates the period totals and loads the output register
// an accepted word is written into the queue and then loaded into the output register
// throughput: one word per cycle when no stall holds, set by the window update in front
// and the counter update in back
// in_stall rises only when the queue holds four words; out_stall holds the
// output register and the queue soaks up the next words meanwhile
// reset clears the window, sequence tracking, counters and queue; rssi min/max
// restart at 127 / -127 and a report with no samples shows 0 for both
module seq_dedup_loss_rssi_stats_top import sdlrs_pkg::*; #(
	parameter int WINDOW_BITS = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [SEQ_W-1:0]   seq_num,
	input  logic [BYTES_W-1:0] payload_bytes,
	input  logic [CHAIN_W-1:0] chain_count,
	input  rssi_t              rssi_chain0,
	input  rssi_t              rssi_chain1,
	input  rssi_t              rssi_chain2,
	input  rssi_t              rssi_chain3,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_report,
	output logic               is_duplicate,
	output logic [CNT_W-1:0]   packet_count,
	output logic [CNT_W-1:0]   lost_count,
	output logic [CNT_W-1:0]   byte_count,
	output rssi_t              rssi_low,
	output rssi_t              rssi_high,
	output logic [SUM_W-1:0]   rssi_total,
	output logic [CNT_W-1:0]   rssi_sample_count
);

	logic   accept;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	entry_t front_entry;
	entry_t back_entry;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	sdlrs_front #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.seq_num      (seq_num),
		.payload_bytes(payload_bytes),
		.chain_count  (chain_count),
		.rssi_chain0  (rssi_chain0),
		.rssi_chain1  (rssi_chain1),
		.rssi_chain2  (rssi_chain2),
		.rssi_chain3  (rssi_chain3),
		.entry        (front_entry)
	);

	sdlrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (back_entry),
		.empty    (q_empty)
	);

	sdlrs_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.entry            (back_entry),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.is_report        (is_report),
		.is_duplicate     (is_duplicate),
		.packet_count     (packet_count),
		.lost_count       (lost_count),
		.byte_count       (byte_count),
		.rssi_low         (rssi_low),
		.rssi_high        (rssi_high),
		.rssi_total       (rssi_total),
		.rssi_sample_count(rssi_sample_count)
	);

endmodule

@@ design/sdlrs_queue.sv @@
// short fifo of classified words between the front and back parts
// depends on sdlrs_pkg
module sdlrs_queue import sdlrs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pop) |=> count_q == $past(count_q))
		else $error("queue count moved on push and pop");
`endif

endmodule

@@ design/sdlrs_front.sv @@
// front part: duplicate window, sequence gap and best chain rssi per frame
// depends on sdlrs_pkg
module sdlrs_front import sdlrs_pkg::*; #(
	parameter int WINDOW_BITS = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               cmd,
	input  logic [SEQ_W-1:0]   seq_num,
	input  logic [BYTES_W-1:0] payload_bytes,
	input  logic [CHAIN_W-1:0] chain_count,
	input  rssi_t              rssi_chain0,
	input  rssi_t              rssi_chain1,
	input  rssi_t              rssi_chain2,
	input  rssi_t              rssi_chain3,
	output entry_t             entry
);

	localparam int IDX_W = $clog2(WINDOW_BITS);

	logic [WINDOW_BITS-1:0] win_q;
	logic [SEQ_W-1:0]       base_q;
	logic                   seen_q;
	logic [SEQ_W-1:0]       next_exp_q;

	logic [SEQ_W-1:0]       seq_ofs;
	logic [SEQ_W-1:0]       shift;
	logic                   far;
	logic [WINDOW_BITS-1:0] win_moved;
	logic [IDX_W-1:0]       bit_idx;
	logic                   dup;
	logic [CHAIN_W-1:0]     nch;
	rssi_t                  chains [NUM_CHAINS];
	rssi_t                  best;
	logic                   rssi_ok;
	logic                   is_frame;

	assign is_frame = accept && (cmd == CMD_FRAME);
	assign seq_ofs  = seq_num - base_q;
	assign far      = (seq_ofs >= SEQ_W'(WINDOW_BITS));
	assign shift    = seq_ofs - SEQ_W'(WINDOW_BITS - 1);

	always_comb begin
		win_moved = win_q;
		bit_idx   = seq_ofs[IDX_W-1:0];
		if (far) begin
			bit_idx = IDX_W'(WINDOW_BITS - 1);
			if (shift >= SEQ_W'(WINDOW_BITS)) begin
				win_moved = '0;
			end else begin
				win_moved = win_q >> shift;
			end
		end
	end

	assign dup = win_moved[bit_idx];

	assign chains[0] = rssi_chain0;
	assign chains[1] = rssi_chain1;
	assign chains[2] = rssi_chain2;
	assign chains[3] = rssi_chain3;
	assign nch = (chain_count > CHAIN_LIMIT) ? CHAIN_LIMIT : chain_count;

	always_comb begin
		best    = RSSI_FLOOR;
		rssi_ok = 1'b0;
		for (int c = 0; c < NUM_CHAINS; c++) begin
			if ((CHAIN_W'(c) < nch) && (chains[c] != RSSI_ABSENT)) begin
				rssi_ok = 1'b1;
				if (chains[c] > best) begin
					best = chains[c];
				end
			end
		end
	end

	always_comb begin
		entry           = '0;
		entry.is_report = (cmd == CMD_REPORT);
		entry.is_dup    = dup;
		entry.bytes     = payload_bytes;
		entry.rssi_ok   = rssi_ok;
		entry.rssi_best = best;
		if (seen_q && (seq_num != next_exp_q)) begin
			entry.gap = seq_num - next_exp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			base_q     <= '0;
			seen_q     <= 1'b0;
			next_exp_q <= '0;
		end else if (is_frame) begin
			win_q <= win_moved | (WINDOW_BITS'(1) << bit_idx);
			if (far) begin
				base_q <= base_q + shift;
			end
			if (!dup) begin
				seen_q     <= 1'b1;
				next_exp_q <= seq_num + 1'b1;
			end
		end
	end

endmodule

@@ design/sdlrs_back.sv @@
// back part: period counters, rssi statistics and the output register
// depends on sdlrs_pkg
module sdlrs_back import sdlrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  entry_t           entry,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             is_report,
	output logic             is_duplicate,
	output logic [CNT_W-1:0] packet_count,
	output logic [CNT_W-1:0] lost_count,
	output logic [CNT_W-1:0] byte_count,
	output rssi_t            rssi_low,
	output rssi_t            rssi_high,
	output logic [SUM_W-1:0] rssi_total,
	output logic [CNT_W-1:0] rssi_sample_count
);

	logic [CNT_W-1:0] pkt_q;
	logic [CNT_W-1:0] lost_q;
	logic [CNT_W-1:0] byte_q;
	rssi_t            min_q;
	rssi_t            max_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] samples_q;
	logic             out_valid_q;

	logic             load;
	logic             upd;
	logic [CNT_W:0]   pkt_add;
	logic [CNT_W:0]   lost_add;
	logic [CNT_W:0]   byte_add;
	logic [CNT_W:0]   samp_add;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_sat;

	assign load  = !q_empty && (!out_valid_q || !out_stall);
	assign q_pop = load;
	assign upd   = load && !entry.is_report && !entry.is_dup;

	assign pkt_add  = {1'b0, pkt_q} + (CNT_W+1)'(1);
	assign lost_add = {1'b0, lost_q} + (CNT_W+1)'(entry.gap);
	assign byte_add = {1'b0, byte_q} + (CNT_W+1)'(entry.bytes);
	assign samp_add = {1'b0, samples_q} + (CNT_W+1)'(1);
	assign sum_add  = {sum_q[SUM_W-1], sum_q}
		+ {{(SUM_W+1-RSSI_W){entry.rssi_best[RSSI_W-1]}}, entry.rssi_best};

	always_comb begin
		sum_sat = sum_add[SUM_W-1:0];
		if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
			sum_sat = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q     <= '0;
			lost_q    <= '0;
			byte_q    <= '0;
			min_q     <= RSSI_MIN_RST;
			max_q     <= RSSI_MAX_RST;
			sum_q     <= '0;
			samples_q <= '0;
		end else if (load && entry.is_report) begin
			pkt_q     <= '0;
			lost_q    <= '0;
			byte_q    <= '0;
			min_q     <= RSSI_MIN_RST;
			max_q     <= RSSI_MAX_RST;
			sum_q     <= '0;
			samples_q <= '0;
		end else if (upd) begin
			pkt_q  <= pkt_add[CNT_W] ? '1 : pkt_add[CNT_W-1:0];
			lost_q <= lost_add[CNT_W] ? '1 : lost_add[CNT_W-1:0];
			byte_q <= byte_add[CNT_W] ? '1 : byte_add[CNT_W-1:0];
			if (entry.rssi_ok) begin
				if (entry.rssi_best < min_q) begin
					min_q <= entry.rssi_best;
				end
				if (entry.rssi_best > max_q) begin
					max_q <= entry.rssi_best;
				end
				sum_q     <= sum_sat;
				samples_q <= samp_add[CNT_W] ? '1 : samp_add[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, frame results carry zero totals
	always_ff @(posedge clk) begin
		if (load) begin
			is_report         <= entry.is_report;
			is_duplicate      <= !entry.is_report && entry.is_dup;
			packet_count      <= entry.is_report ? pkt_q : '0;
			lost_count        <= entry.is_report ? lost_q : '0;
			byte_count        <= entry.is_report ? byte_q : '0;
			rssi_low          <= (entry.is_report && samples_q != '0) ? min_q : '0;
			rssi_high         <= (entry.is_report && samples_q != '0) ? max_q : '0;
			rssi_total        <= entry.is_report ? sum_q : '0;
			rssi_sample_count <= entry.is_report ? samples_q : '0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !is_report) |-> (packet_count == '0 && lost_count == '0
		&& byte_count == '0 && rssi_sample_count == '0 && rssi_total == '0))
		else $error("frame result carries totals");
	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && entry.is_report) |=> (pkt_q == '0 && samples_q == '0 && sum_q == '0))
		else $error("report did not clear period");
	a_report_not_dup: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_report) |-> !is_duplicate)
		else $error("report marked duplicate");
`endif

endmodule

@@ dv/seq_dedup_loss_rssi_stats_top_tb.sv @@
// testbench for seq_dedup_loss_rssi_stats_top: directed and random frame/report words
// checked in order against a built-in duplicate window and period statistics predictor
// depends on sdlrs_pkg and the design sources only
module seq_dedup_loss_rssi_stats_top_tb;
	import sdlrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW = 128;
	localparam int WIN_IDX_W = $clog2(WINDOW);
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTED = 10;
	localparam longint SUM_HI = 64'sd549755813887;
	localparam longint SUM_LO = -64'sd549755813888;

	typedef struct packed {
		logic                          cmd;
		logic [SEQ_W-1:0]              seq;
		logic [BYTES_W-1:0]            octets;
		logic [CHAIN_W-1:0]            chains;
		logic [3:0][RSSI_W-1:0]        rssi;
	} frame_word_t;

	typedef struct packed {
		logic              is_report;
		logic              is_dup;
		logic [CNT_W-1:0]  pkts;
		logic [CNT_W-1:0]  lost;
		logic [CNT_W-1:0]  octets;
		logic [RSSI_W-1:0] low;
		logic [RSSI_W-1:0] high;
		logic [SUM_W-1:0]  total;
		logic [CNT_W-1:0]  samples;
	} stats_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = CMD_FRAME;
	logic [SEQ_W-1:0]   seq_num = '0;
	logic [BYTES_W-1:0] payload_bytes = '0;
	logic [CHAIN_W-1:0] chain_count = '0;
	rssi_t              rssi_chain0 = '0;
	rssi_t              rssi_chain1 = '0;
	rssi_t              rssi_chain2 = '0;
	rssi_t              rssi_chain3 = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               is_report;
	logic               is_duplicate;
	logic [CNT_W-1:0]   packet_count;
	logic [CNT_W-1:0]   lost_count;
	logic [CNT_W-1:0]   byte_count;
	rssi_t              rssi_low;
	rssi_t              rssi_high;
	logic [SUM_W-1:0]   rssi_total;
	logic [CNT_W-1:0]   rssi_sample_count;

	seq_dedup_loss_rssi_stats_top dut (.*);

	always #5 clk = ~clk;

	frame_word_t stim_q[$];
	stats_word_t stats_q[$];
	frame_word_t held_word;
	int send_idle = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic [SEQ_W-1:0] last_seq = '0;

	// predictor state
	logic [WINDOW-1:0] seen_map = '0;
	logic [SEQ_W-1:0]  map_base = '0;
	logic              seq_started = 1'b0;
	logic [SEQ_W-1:0]  next_seq = '0;
	logic [CNT_W-1:0]  pkt_tally = '0;
	logic [CNT_W-1:0]  lost_tally = '0;
	logic [CNT_W-1:0]  octet_tally = '0;
	int                rssi_floor = 127;
	int                rssi_peak = -127;
	longint            sum_tally = 0;
	logic [CNT_W-1:0]  sample_tally = '0;

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic logic mark_seen(input logic [SEQ_W-1:0] seq);
		logic [SEQ_W-1:0] ofs;
		logic [SEQ_W-1:0] shift;
		logic hit;
		ofs = seq - map_base;
		if (ofs >= WINDOW) begin
			shift = ofs - SEQ_W'(WINDOW - 1);
			if (shift >= WINDOW)
				seen_map = '0;
			else
				seen_map = seen_map >> shift;
			map_base = map_base + shift;
			ofs = SEQ_W'(WINDOW - 1);
		end
		hit = seen_map[ofs[WIN_IDX_W-1:0]];
		seen_map[ofs[WIN_IDX_W-1:0]] = 1'b1;
		return hit;
	endfunction

	function automatic stats_word_t tally_word(input frame_word_t w);
		stats_word_t res;
		logic [SEQ_W-1:0] gap;
		int n;
		int r;
		int best;
		logic got_rssi;
		res = '0;
		if (w.cmd == CMD_REPORT) begin
			res.is_report = 1'b1;
			res.pkts = pkt_tally;
			res.lost = lost_tally;
			res.octets = octet_tally;
			res.low = (sample_tally != 0) ? RSSI_W'(rssi_floor) : '0;
			res.high = (sample_tally != 0) ? RSSI_W'(rssi_peak) : '0;
			res.total = SUM_W'(sum_tally);
			res.samples = sample_tally;
			pkt_tally = '0;
			lost_tally = '0;
			octet_tally = '0;
			rssi_floor = 127;
			rssi_peak = -127;
			sum_tally = 0;
			sample_tally = '0;
			return res;
		end
		res.is_dup = mark_seen(w.seq);
		if (res.is_dup)
			return res;
		if (seq_started && w.seq != next_seq) begin
			gap = w.seq - next_seq;
			lost_tally = sat_sum(lost_tally, CNT_W'(gap));
		end
		seq_started = 1'b1;
		next_seq = w.seq + 1'b1;
		n = (w.chains > 4) ? 4 : int'(w.chains);
		best = -127;
		got_rssi = 1'b0;
		for (int c = 0; c < n; c++) begin
			r = $signed(w.rssi[c]);
			if (r != int'(RSSI_ABSENT)) begin
				got_rssi = 1'b1;
				if (r > best)
					best = r;
			end
		end
		if (got_rssi) begin
			if (best < rssi_floor)
				rssi_floor = best;
			if (best > rssi_peak)
				rssi_peak = best;
			sum_tally = sum_tally + best;
			if (sum_tally > SUM_HI)
				sum_tally = SUM_HI;
			if (sum_tally < SUM_LO)
				sum_tally = SUM_LO;
			sample_tally = sat_sum(sample_tally, CNT_W'(1));
		end
		pkt_tally = sat_sum(pkt_tally, CNT_W'(1));
		octet_tally = sat_sum(octet_tally, CNT_W'(w.octets));
		return res;
	endfunction

	// driver: predicts each accepted word, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				stats_q.push_back(tally_word(held_word));
			if (!in_valid || !in_stall) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					held_word = stim_q.pop_front();
					in_valid <= 1'b1;
					cmd <= held_word.cmd;
					seq_num <= held_word.seq;
					payload_bytes <= held_word.octets;
					chain_count <= held_word.chains;
					rssi_chain0 <= held_word.rssi[0];
					rssi_chain1 <= held_word.rssi[1];
					rssi_chain2 <= held_word.rssi[2];
					rssi_chain3 <= held_word.rssi[3];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_field(input string field, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTED)
			$display("%t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
	endtask

	// monitor: random back-pressure and in-order compare
	always @(posedge clk or negedge arst_n) begin
		stats_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (stats_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display("%t: result word with nothing expected", $realtime);
				end else begin
					want = stats_q.pop_front();
					if (is_report !== want.is_report)
						flag_field("is_report", want.is_report, is_report);
					if (is_duplicate !== want.is_dup)
						flag_field("is_duplicate", want.is_dup, is_duplicate);
					if (packet_count !== want.pkts)
						flag_field("packet_count", want.pkts, packet_count);
					if (lost_count !== want.lost)
						flag_field("lost_count", want.lost, lost_count);
					if (byte_count !== want.octets)
						flag_field("byte_count", want.octets, byte_count);
					if (rssi_low !== want.low)
						flag_field("rssi_low", want.low, rssi_low);
					if (rssi_high !== want.high)
						flag_field("rssi_high", want.high, rssi_high);
					if (rssi_total !== want.total)
						flag_field("rssi_total", want.total, rssi_total);
					if (rssi_sample_count !== want.samples)
						flag_field("rssi_sample_count", want.samples, rssi_sample_count);
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic add_word(input logic c, input logic [SEQ_W-1:0] s,
			input logic [BYTES_W-1:0] b, input logic [CHAIN_W-1:0] n,
			input rssi_t r0, input rssi_t r1, input rssi_t r2, input rssi_t r3);
		frame_word_t w;
		w.cmd = c;
		w.seq = s;
		w.octets = b;
		w.chains = n;
		w.rssi = {r3, r2, r1, r0};
		stim_q.push_back(w);
	endtask

	task automatic add_random_words(input int count);
		frame_word_t w;
		int pick;
		for (int k = 0; k < count; k++) begin
			w.cmd = CMD_FRAME;
			w.seq = SEQ_W'($urandom);
			w.octets = BYTES_W'($urandom);
			w.chains = CHAIN_W'($urandom_range(7));
			for (int c = 0; c < 4; c++)
				w.rssi[c] = ($urandom_range(99) < 15) ? RSSI_ABSENT : RSSI_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 6) begin
				w.cmd = CMD_REPORT;
			end else if (pick < 70) begin
				last_seq = last_seq + 1'b1 +
					(($urandom_range(3) == 0) ? SEQ_W'($urandom_range(5)) : '0);
				w.seq = last_seq;
			end else if (pick < 82) begin
				// resend of a recent word, or one just behind the window
				w.seq = last_seq - SEQ_W'($urandom_range(140));
			end else if (pick < 90) begin
				last_seq = last_seq + SEQ_W'($urandom_range(100, 300));
				w.seq = last_seq;
			end else begin
				last_seq = w.seq;
			end
			stim_q.push_back(w);
		end
	endtask

	task automatic drain_stimulus();
		while (stim_q.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	initial begin
		send_idle = 21;
		recv_stall = 76;
		// first frame, max payload, chain clamp, absent chains, report with no samples
		add_word(CMD_FRAME, 12'd0, 12'd0, 3'd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0);
		add_word(CMD_FRAME, 12'd1, 12'hfff, 3'd4, -8'sd127, 8'sd127, RSSI_ABSENT, 8'sd0);
		add_word(CMD_FRAME, 12'd1, 12'd100, 3'd1, 8'sd5, 8'sd5, 8'sd5, 8'sd5);
		add_word(CMD_FRAME, 12'd5, 12'haaa, 3'd7, RSSI_ABSENT, RSSI_ABSENT, RSSI_ABSENT,
			RSSI_ABSENT);
		add_word(CMD_FRAME, 12'd6, 12'd1, 3'd1, RSSI_ABSENT, 8'sd50, 8'sd50, 8'sd50);
		add_word(CMD_FRAME, 12'd7, 12'd2, 3'd3, -8'sd127, -8'sd127, RSSI_ABSENT, 8'sd100);
		add_word(CMD_REPORT, 12'd0, 12'd0, 3'd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0);
		add_word(CMD_REPORT, 12'hfff, 12'hfff, 3'd7, -8'sd1, -8'sd1, -8'sd1, -8'sd1);
		// window edge, one-step slide, backward clear, far-ahead clear, kept bit
		add_word(CMD_FRAME, 12'd127, 12'd10, 3'd2, -8'sd40, -8'sd30, 8'sd0, 8'sd0);
		add_word(CMD_FRAME, 12'd128, 12'd11, 3'd4, 8'sd1, 8'sd2, 8'sd3, 8'sd4);
		add_word(CMD_FRAME, 12'd0, 12'd12, 3'd5, 8'sd9, RSSI_ABSENT, 8'sd8, -8'sd9);
		add_word(CMD_FRAME, 12'd0, 12'd13, 3'd1, 8'sd7, 8'sd0, 8'sd0, 8'sd0);
		add_word(CMD_FRAME, 12'd300, 12'd14, 3'd6, -8'sd60, -8'sd61, -8'sd62, -8'sd63);
		add_word(CMD_FRAME, 12'd200, 12'd15, 3'd2, 8'sd20, 8'sd21, 8'sd0, 8'sd0);
		add_word(CMD_FRAME, 12'd200, 12'd16, 3'd2, 8'sd20, 8'sd21, 8'sd0, 8'sd0);
		// sequence wrap
		add_word(CMD_FRAME, 12'hfff, 12'h555, 3'd2, 8'sh55, 8'shaa, 8'sd0, 8'sd0);
		add_word(CMD_FRAME, 12'd0, 12'haaa, 3'd3, 8'shaa, 8'sh55, 8'sh7f, 8'sd0);
		add_word(CMD_FRAME, 12'h800, 12'h7ff, 3'd4, 8'sd127, 8'sd127, 8'sd127, 8'sd127);
		add_word(CMD_FRAME, 12'h7ff, 12'h800, 3'd4, -8'sd127, RSSI_ABSENT, RSSI_ABSENT,
			RSSI_ABSENT);
		add_word(CMD_REPORT, 12'h5a5, 12'ha5a, 3'd4, 8'sd1, 8'sd1, 8'sd1, 8'sd1);
		last_seq = 12'h800;
		add_random_words(460);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		drain_stimulus();
		send_idle = 76;
		recv_stall = 21;
		add_random_words(485);
		drain_stimulus();
		send_idle = 0;
		recv_stall = 0;
		add_random_words(485);
		drain_stimulus();

		while (stats_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && stats_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ seq_dedup_loss_rssi_stats_top.f @@
design/sdlrs_pkg.sv
design/sdlrs_queue.sv
design/sdlrs_front.sv
design/sdlrs_back.sv
design/seq_dedup_loss_rssi_stats_top.sv
dv/seq_dedup_loss_rssi_stats_top_tb.sv
